// ----- src/bilinear_biquad_coefficients_assert.svh -----
// Assertion macros shared by the RTL files.
`ifndef BILINEAR_BIQUAD_COEFFICIENTS_ASSERT_SVH
`define BILINEAR_BIQUAD_COEFFICIENTS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define BBC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bbc assertion failed");
// checked during reset as well
`define BBC_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bbc assertion failed");
`else
`define BBC_ASSERT(lbl, clk, rst, prop)
`define BBC_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ----- src/bbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bbc_pkg;

  localparam int COEF_W  = 32;
  localparam int POLY_W  = 104;  // scaled polynomial values, below 2^100 in magnitude
  localparam int DEN_W   = 105;  // twice the normaliser
  localparam int REM_W   = 136;
  localparam int QBITS   = 32;
  localparam int DIV_LAT = QBITS + 3;

  localparam logic [COEF_W-1:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_TS   = 2'd1,
    ST_UNST = 2'd2
  } st_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_33 = 2'd1,
    SH_66 = 2'd2
  } sh_t;

  localparam logic CFG_MIN_TS = 1'b0;
  localparam logic CFG_TOL    = 1'b1;

  typedef struct packed {
    logic               func;
    logic signed [31:0] num_s2;
    logic signed [31:0] num_s1;
    logic signed [31:0] num_s0;
    logic signed [31:0] den_s2;
    logic signed [31:0] den_s1;
    logic signed [31:0] den_s0;
    logic        [31:0] timestep;
  } coef_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
  } disc_t;

endpackage
`default_nettype wire

// ----- src/bilinear_biquad_coefficients.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Tustin discretisation of a first or second order transfer function.
// Input channel coef/coef_valid/coef_stall carries one continuous coefficient
// set per transfer; output channel disc/disc_valid/disc_stall returns b0..b2,
// a1, a2 (a0 = 1) and a status, one result per input, in order.
// Stages: input register with the timestep square, two multiplier stages, the
// polynomial sums, and a 35-stage divider resolving the quotient bit by bit
// for all five coefficients at once. Throughput is one item per cycle while
// not stalled; the divider pipeline sets the depth. cfg_we/cfg_index/cfg_data
// write min_timestep (0) or stability_tolerance (1); the user must do so only
// while the block is idle; the block does not enforce it. Reset empties the
// pipeline and restores the register defaults. When disc_stall holds a
// waiting result the whole pipeline freezes and coef_stall rises; nothing is
// lost or repeated. Errors return b0 = 1.0 and zero elsewhere, status 1 or 2.
module bilinear_biquad_coefficients (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           coef_valid,
  output logic                coef_stall,
  input  wire bbc_pkg::coef_t coef,
  output logic                disc_valid,
  input  wire logic           disc_stall,
  output bbc_pkg::disc_t      disc,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire logic [31:0]    cfg_data
);

  localparam int L_N2  = 0;
  localparam int L_N1  = 1;
  localparam int L_N0  = 2;
  localparam int L_D2  = 3;
  localparam int L_D1  = 4;
  localparam int L_D0  = 5;
  localparam int L_TOL = 6;
  localparam int NL    = 7;
  localparam int NQ    = 5;

  logic        [31:0] min_timestep;
  logic        [15:0] stability_tolerance;

  logic en;
  logic [63:0] tsq_in;
  logic        err1_in;

  logic               vld_a, vld_b, vld_c, vld_d;
  bbc_pkg::coef_t     in_a;
  logic [63:0]        tsq_a;
  logic               err1_a, err1_b, err1_c;
  logic               func_b, func_c;

  logic signed [32:0]                   coef_l [0:NL-1];
  logic        [63:0]                   wgt_l  [0:NL-1];
  bbc_pkg::sh_t                         sh_l   [0:NL-1];
  logic signed [bbc_pkg::POLY_W-1:0]    term_l [0:NL-1];

  logic signed [bbc_pkg::POLY_W-1:0] c_sum;
  logic signed [bbc_pkg::POLY_W-1:0] num_sum [0:NQ-1];
  logic signed [bbc_pkg::POLY_W-1:0] c_d;
  logic signed [bbc_pkg::POLY_W-1:0] num_d   [0:NQ-1];
  bbc_pkg::st_t                      st_c;
  bbc_pkg::st_t                      st_d;
  bbc_pkg::st_t                      st_dly  [0:bbc_pkg::DIV_LAT-1];

  logic                              vld_q   [0:NQ-1];
  logic signed [bbc_pkg::COEF_W-1:0] quo_q   [0:NQ-1];

  assign en         = !disc_valid || !disc_stall;
  assign coef_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_timestep        <= 32'd4295;
      stability_tolerance <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        bbc_pkg::CFG_MIN_TS: min_timestep        <= cfg_data;
        bbc_pkg::CFG_TOL:    stability_tolerance <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage A: capture, timestep square, timestep check
  assign tsq_in  = coef.timestep * coef.timestep;
  assign err1_in = (coef.timestep == 32'd0) || (coef.timestep < min_timestep);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      vld_d <= 1'b0;
    end else if (en) begin
      vld_a <= coef_valid;
      vld_b <= vld_a;
      vld_c <= vld_b;
      vld_d <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_a   <= coef;
      tsq_a  <= tsq_in;
      err1_a <= err1_in;
      err1_b <= err1_a;
      err1_c <= err1_b;
      func_b <= in_a.func;
      func_c <= func_b;
    end
  end

  // weights: second order 2^66, 2^33 T, T^2; first order 2^33, T
  always_comb begin
    coef_l[L_N1]  = 33'(in_a.num_s1);
    coef_l[L_N0]  = 33'(in_a.num_s0);
    coef_l[L_D1]  = 33'(in_a.den_s1);
    coef_l[L_D0]  = 33'(in_a.den_s0);
    coef_l[L_TOL] = $signed({17'd0, stability_tolerance});
    if (in_a.func) begin
      coef_l[L_N2] = 33'(in_a.num_s2);
      coef_l[L_D2] = 33'(in_a.den_s2);
      wgt_l[L_N2]  = 64'd1;
      wgt_l[L_D2]  = 64'd1;
      wgt_l[L_N1]  = 64'(in_a.timestep);
      wgt_l[L_D1]  = 64'(in_a.timestep);
      wgt_l[L_N0]  = tsq_a;
      wgt_l[L_D0]  = tsq_a;
      wgt_l[L_TOL] = tsq_a;
      sh_l[L_N2]   = bbc_pkg::SH_66;
      sh_l[L_D2]   = bbc_pkg::SH_66;
      sh_l[L_N1]   = bbc_pkg::SH_33;
      sh_l[L_D1]   = bbc_pkg::SH_33;
    end else begin
      coef_l[L_N2] = '0;
      coef_l[L_D2] = '0;
      wgt_l[L_N2]  = 64'd0;
      wgt_l[L_D2]  = 64'd0;
      wgt_l[L_N1]  = 64'd1;
      wgt_l[L_D1]  = 64'd1;
      wgt_l[L_N0]  = 64'(in_a.timestep);
      wgt_l[L_D0]  = 64'(in_a.timestep);
      wgt_l[L_TOL] = 64'(in_a.timestep);
      sh_l[L_N2]   = bbc_pkg::SH_0;
      sh_l[L_D2]   = bbc_pkg::SH_0;
      sh_l[L_N1]   = bbc_pkg::SH_33;
      sh_l[L_D1]   = bbc_pkg::SH_33;
    end
    sh_l[L_N0]  = bbc_pkg::SH_0;
    sh_l[L_D0]  = bbc_pkg::SH_0;
    sh_l[L_TOL] = bbc_pkg::SH_0;
  end

  for (genvar l = 0; l < NL; l++) begin : g_lane
    bbc_term u_term (
      .clk  (clk),
      .en   (en),
      .coef (coef_l[l]),
      .wgt  (wgt_l[l]),
      .sh   (sh_l[l]),
      .term (term_l[l])
    );
  end

  // stage D: scaled polynomials and normaliser check
  always_comb begin
    c_sum = term_l[L_D2] + term_l[L_D1] + term_l[L_D0];
    num_sum[0] = term_l[L_N2] + term_l[L_N1] + term_l[L_N0];
    if (func_c) begin
      num_sum[1] = (term_l[L_N0] - term_l[L_N2]) <<< 1;
      num_sum[2] = term_l[L_N2] - term_l[L_N1] + term_l[L_N0];
      num_sum[3] = (term_l[L_D0] - term_l[L_D2]) <<< 1;
      num_sum[4] = term_l[L_D2] - term_l[L_D1] + term_l[L_D0];
    end else begin
      num_sum[1] = term_l[L_N0] - term_l[L_N1];
      num_sum[2] = '0;
      num_sum[3] = term_l[L_D0] - term_l[L_D1];
      num_sum[4] = '0;
    end
    if (err1_c) begin
      st_c = bbc_pkg::ST_TS;
    end else if ((c_sum <= 0) || (c_sum < term_l[L_TOL])) begin
      st_c = bbc_pkg::ST_UNST;
    end else begin
      st_c = bbc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_d  <= c_sum;
      st_d <= st_c;
      for (int i = 0; i < NQ; i++) num_d[i] <= num_sum[i];
      st_dly[0] <= st_d;
      for (int i = 1; i < bbc_pkg::DIV_LAT; i++) st_dly[i] <= st_dly[i-1];
    end
  end

  for (genvar q = 0; q < NQ; q++) begin : g_div
    bbc_div u_div (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .vld_in  (vld_d),
      .live_in (vld_d && (st_d == bbc_pkg::ST_OK)),
      .num_in  (num_d[q]),
      .den_in  (c_d),
      .vld_out (vld_q[q]),
      .quo     (quo_q[q])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      disc_valid <= 1'b0;
    end else if (en) begin
      disc_valid <= vld_q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc.status <= st_dly[bbc_pkg::DIV_LAT-1];
      if (st_dly[bbc_pkg::DIV_LAT-1] == bbc_pkg::ST_OK) begin
        disc.b0 <= quo_q[0];
        disc.b1 <= quo_q[1];
        disc.b2 <= quo_q[2];
        disc.a1 <= quo_q[3];
        disc.a2 <= quo_q[4];
      end else begin
        disc.b0 <= bbc_pkg::ONE_Q16;
        disc.b1 <= '0;
        disc.b2 <= '0;
        disc.a1 <= '0;
        disc.a2 <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/bbc_term.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Signed coefficient times a 64-bit weight, then a fixed power-of-two scale.
// Two stages: split 33x33 partial products, then recombine and shift.
module bbc_term (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic signed [32:0]                 coef,
  input  wire logic        [63:0]                 wgt,
  input  wire bbc_pkg::sh_t                       sh,
  output logic signed [bbc_pkg::POLY_W-1:0]       term
);

  logic signed [65:0] plo;
  logic signed [65:0] phi;
  bbc_pkg::sh_t       shr;
  logic signed [bbc_pkg::POLY_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      plo <= coef * $signed({1'b0, wgt[31:0]});
      phi <= coef * $signed({1'b0, wgt[63:32]});
      shr <= sh;
    end
  end

  assign sum = bbc_pkg::POLY_W'(plo) + (bbc_pkg::POLY_W'(phi) <<< 32);

  always_ff @(posedge clk) begin
    if (en) begin
      case (shr)
        bbc_pkg::SH_0:  term <= sum;
        bbc_pkg::SH_33: term <= sum <<< 33;
        bbc_pkg::SH_66: term <= sum <<< 66;
        default:        term <= sum;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/bbc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_biquad_coefficients_assert.svh"
// Rounded, saturating quotient n * 2^16 / d, one quotient bit per bit stage.
module bbc_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                vld_in,
  input  wire logic                                live_in,
  input  wire logic signed [bbc_pkg::POLY_W-1:0]   num_in,
  input  wire logic signed [bbc_pkg::POLY_W-1:0]   den_in,
  output logic                                     vld_out,
  output logic signed [bbc_pkg::COEF_W-1:0]        quo
);

  localparam int NS = bbc_pkg::QBITS + 1;

  logic                              vld_p;
  logic                              live_p;
  logic                              neg_p;
  logic [bbc_pkg::POLY_W-1:0]        mag_p;
  logic [bbc_pkg::POLY_W-1:0]        den_p;
  logic [bbc_pkg::REM_W-1:0]         num_q;

  logic [NS-1:0]                     vld_s;
  logic [NS-1:0]                     live_s;
  logic [NS-1:0]                     neg_s;
  logic [NS-1:0]                     ovf_s;
  logic [bbc_pkg::REM_W-1:0]         rem_s [0:NS-1];
  logic [bbc_pkg::DEN_W-1:0]         den_s [0:NS-1];
  logic [bbc_pkg::QBITS-1:0]         q_s   [0:NS-1];

  logic [bbc_pkg::QBITS-1:0]         qf;
  logic                              sat;
  logic                              fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_p  <= 1'b0;
      live_p <= 1'b0;
      vld_s[0]  <= 1'b0;
      live_s[0] <= 1'b0;
    end else if (en) begin
      vld_p  <= vld_in;
      live_p <= live_in;
      vld_s[0]  <= vld_p;
      live_s[0] <= live_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_p <= num_in[bbc_pkg::POLY_W-1];
      mag_p <= num_in[bbc_pkg::POLY_W-1] ? bbc_pkg::POLY_W'(-num_in)
                                         : bbc_pkg::POLY_W'(num_in);
      den_p <= den_in;
    end
  end

  // rounding bias: (2m + 1 after the shift) over 2d
  assign num_q = (bbc_pkg::REM_W'(mag_p) << 17) + bbc_pkg::REM_W'(den_p);

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s[0] <= neg_p;
      rem_s[0] <= num_q;
      den_s[0] <= {den_p, 1'b0};
      ovf_s[0] <= num_q >= (bbc_pkg::REM_W'({den_p, 1'b0}) << bbc_pkg::QBITS);
      q_s[0]   <= '0;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_bit
    localparam int B = bbc_pkg::QBITS - k;
    logic [bbc_pkg::REM_W-1:0] cmp;
    logic                      hit;
    assign cmp = bbc_pkg::REM_W'(den_s[k-1]) << B;
    assign hit = rem_s[k-1] >= cmp;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k]  <= 1'b0;
        live_s[k] <= 1'b0;
      end else if (en) begin
        vld_s[k]  <= vld_s[k-1];
        live_s[k] <= live_s[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k] <= hit ? rem_s[k-1] - cmp : rem_s[k-1];
        q_s[k]   <= q_s[k-1] | (bbc_pkg::QBITS'(hit) << B);
        den_s[k] <= den_s[k-1];
        neg_s[k] <= neg_s[k-1];
        ovf_s[k] <= ovf_s[k-1];
      end
    end
  end

  assign qf  = q_s[NS-1];
  assign sat = neg_s[NS-1] ? (ovf_s[NS-1] | (qf[31] & (|qf[30:0])))
                           : (ovf_s[NS-1] | qf[31]);

  // remainder is only bounded when the quotient fits in QBITS
  assign fits = live_s[NS-1] && !ovf_s[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld_s[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_s[NS-1]) begin
        quo <= sat ? 32'sh8000_0000 : $signed(-qf);
      end else begin
        quo <= sat ? 32'sh7FFF_FFFF : $signed(qf);
      end
    end
  end

  `BBC_ASSERT_NR(a_div_flush, clk, rst |=> !vld_p && !vld_s[0] && !vld_out)
  `BBC_ASSERT(a_div_rem, clk, rst, fits |-> rem_s[NS-1] < bbc_pkg::REM_W'(den_s[NS-1]))
  `BBC_ASSERT(a_div_hold, clk, rst, !en |=> $stable(vld_out) && $stable(quo))

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import bbc_pkg::*;

  // Predicts the discrete coefficients and holds them until the block returns them.
  class coef_scoreboard;
    disc_t           awaited[$];
    logic     [31:0] min_ts;
    logic     [15:0] tol;
    int              errors;
    int              n_ok, n_ts, n_unst;

    function new();
      min_ts = 32'd4295;
      tol    = 16'd0;
      errors = 0;
      n_ok = 0; n_ts = 0; n_unst = 0;
    endfunction

    function logic signed [199:0] sx(logic [31:0] r);
      return {{168{r[31]}}, r};
    endfunction

    // round(n * 2^16 / c), ties away from zero, saturated to 32 bits
    function logic [31:0] ratio(logic signed [199:0] n, logic signed [199:0] c);
      logic signed [199:0] mag, q;
      mag = (n < 0) ? -n : n;
      q = ((mag <<< 17) + c) / (c <<< 1);
      if (n < 0) begin
        if (q > 200'sh8000_0000) return 32'h8000_0000;
        return 32'(-q);
      end
      if (q > 200'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      return q[31:0];
    endfunction

    function disc_t tustin(coef_t x);
      logic signed [199:0] t, w2, w1, w0, n2, n1, n0, d2, d1, d0, c, tolw;
      disc_t r;
      r = '0;
      r.b0 = ONE_Q16;
      r.status = ST_TS;
      t = {168'b0, x.timestep};
      if (x.timestep == 0 || x.timestep < min_ts) return r;
      if (x.func) begin
        w2 = 200'sd1 <<< 66;
        w1 = t <<< 33;
        w0 = t * t;
      end else begin
        w2 = 0;
        w1 = 200'sd1 <<< 33;
        w0 = t;
      end
      n2 = sx(x.num_s2) * w2; n1 = sx(x.num_s1) * w1; n0 = sx(x.num_s0) * w0;
      d2 = sx(x.den_s2) * w2; d1 = sx(x.den_s1) * w1; d0 = sx(x.den_s0) * w0;
      c = d2 + d1 + d0;
      tolw = {184'b0, tol} * w0;
      if (c <= 0 || c < tolw) begin
        r.status = ST_UNST;
        return r;
      end
      r.status = ST_OK;
      r.b0 = ratio(n2 + n1 + n0, c);
      r.b1 = ratio(x.func ? 2 * (n0 - n2) : n0 - n1, c);
      r.a1 = ratio(x.func ? 2 * (d0 - d2) : d0 - d1, c);
      r.b2 = x.func ? ratio(n2 - n1 + n0, c) : 32'd0;
      r.a2 = x.func ? ratio(d2 - d1 + d0, c) : 32'd0;
      return r;
    endfunction

    function void note(coef_t x);
      awaited.push_back(tustin(x));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check(disc_t d);
      disc_t e;
      if (awaited.size() == 0) begin
        report("unexpected result", d.b0, 32'd0);
        return;
      end
      e = awaited.pop_front();
      if (d.status != e.status) report("status", d.status, e.status);
      if (d.b0 != e.b0) report("b0", d.b0, e.b0);
      if (d.b1 != e.b1) report("b1", d.b1, e.b1);
      if (d.b2 != e.b2) report("b2", d.b2, e.b2);
      if (d.a1 != e.a1) report("a1", d.a1, e.a1);
      if (d.a2 != e.a2) report("a2", d.a2, e.a2);
      case (e.status)
        ST_OK:   n_ok++;
        ST_TS:   n_ts++;
        default: n_unst++;
      endcase
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        coef_valid;
  logic        coef_stall;
  coef_t       coef;
  logic        disc_valid;
  logic        disc_stall;
  disc_t       disc;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  coef_scoreboard sb = new();
  bit quiet;
  bit long_hold;

  bilinear_biquad_coefficients DUT (
    .clk(clk), .rst(rst),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coef(coef),
    .disc_valid(disc_valid), .disc_stall(disc_stall), .disc(disc),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (coef_valid && !coef_stall) sb.note(coef);
      if (disc_valid && !disc_stall) sb.check(disc);
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    disc_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        disc_stall <= 1'b1;
        repeat (300) @(negedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        disc_stall <= 1'b1;
        repeat ($urandom_range(1, 15) - 1) @(negedge clk);
      end else begin
        disc_stall <= 1'b0;
      end
    end
  end

  task automatic send(coef_t x);
    @(negedge clk);
    coef <= x;
    coef_valid <= 1'b1;
    @(posedge clk);
    while (coef_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      coef_valid <= 1'b0;
      repeat ($urandom_range(1, 15) - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    coef_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic cfg_write(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_TS) sb.min_ts = val;
    else sb.tol = val[15:0];
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic coef_t rand_item();
    coef_t x;
    x.func = $urandom_range(0, 1);
    x.num_s2 = pick_coef(); x.num_s1 = pick_coef(); x.num_s0 = pick_coef();
    x.den_s2 = pick_coef(); x.den_s1 = pick_coef(); x.den_s0 = pick_coef();
    // mostly positive denominators so that most items pass the stability test
    if ($urandom_range(0, 3) != 0) begin
      x.den_s2[31] = 1'b0; x.den_s1[31] = 1'b0; x.den_s0[31] = 1'b0;
    end
    case ($urandom_range(0, 4))
      0: x.timestep = $urandom;
      1: x.timestep = sb.min_ts + $urandom_range(0, 2) - 1;
      2: x.timestep = $urandom_range(0, 3);
      default: x.timestep = $urandom_range(4000, 4_000_000);
    endcase
    return x;
  endfunction

  function automatic coef_t mk(bit f, logic [31:0] n2, n1, n0, d2, d1, d0, ts);
    coef_t x;
    x.func = f; x.num_s2 = n2; x.num_s1 = n1; x.num_s0 = n0;
    x.den_s2 = d2; x.den_s1 = d1; x.den_s0 = d0; x.timestep = ts;
    return x;
  endfunction

  task automatic random_run(int n);
    repeat (n) send(rand_item());
  endtask

  initial begin
    rst = 1'b1;
    coef_valid = 1'b0;
    coef = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_MIN_TS;
    cfg_data = '0;
    quiet = 0;
    long_hold = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed items at the reset settings
    send(mk(1, 32'h1_0000, 32'h2_0000, 32'h1_0000, 32'h1_0000, 32'h3_0000, 32'h2_0000, 429497));
    send(mk(0, 32'hDEAD_BEEF, 32'h1_0000, 32'h1_0000, 32'hCAFE_F00D, 32'h1_0000,
            32'h1_0000, 4295));
    send(mk(1, 0, 0, 0, 0, 0, 0, 0));                      // zero timestep
    send(mk(1, 0, 0, 0, 32'h1_0000, 0, 0, 4294));          // one below minimum
    send(mk(1, 0, 0, 0, 0, 0, 0, 42949));                  // zero denominator
    send(mk(0, 0, 0, 0, 0, 32'hFFFF_0000, 0, 42949));      // negative denominator
    send(mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1, 32'hFFFF_FFFF));
    send(mk(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 32'hFFFF_FFFF));
    send(mk(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'hFFFF_FFFF));
    send(mk(1, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4295));
    send(mk(0, 0, 32'h1, 32'hFFFF_FFFF, 0, 32'h1, 32'h1, 32'hFFFF_FFFF));
    drain();

    cfg_write(CFG_MIN_TS, 32'd0);
    cfg_write(CFG_TOL, 32'd0);
    send(mk(0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1_0000, 0));   // zero still rejected
    send(mk(1, 0, 0, 32'h1_0000, 0, 0, 32'h1_0000, 1));
    random_run(200);
    // long receiver hold while the sender keeps offering
    long_hold = 1;
    random_run(100);
    drain();

    cfg_write(CFG_MIN_TS, 32'hFFFF_FFFF);
    cfg_write(CFG_TOL, 32'h0000_FFFF);
    send(mk(1, 0, 0, 32'h1_0000, 0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send(mk(0, 0, 0, 32'h1_0000, 0, 0, 32'h0000_FFFF, 32'hFFFF_FFFF));  // exactly at tolerance
    send(mk(0, 0, 0, 32'h1_0000, 0, 0, 32'h0000_FFFE, 32'hFFFF_FFFF));  // just below
    random_run(60);
    drain();

    cfg_write(CFG_MIN_TS, 32'd1000);
    cfg_write(CFG_TOL, 32'h0000_8000);
    random_run(200);
    drain();

    cfg_write(CFG_MIN_TS, 32'd4295);
    cfg_write(CFG_TOL, 32'd1);
    quiet = 1;
    random_run(120);
    drain();

    $display("covered %0d ok, %0d timestep and %0d stability results over five settings",
             sb.n_ok, sb.n_ts, sb.n_unst);
    $display("including a long output hold and back-to-back transfers at the end");
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("[bilinear_biquad_coefficients] OK");
    end else begin
      $display("[bilinear_biquad_coefficients] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[bilinear_biquad_coefficients] ERROR");
    $finish;
  end

endmodule
